// ===== hw/rtl/hps_pkg.sv =====
// hps_pkg: shared types, sizes and codes for the heap priority scheduler.
// No dependencies.
`timescale 1ns / 1ps
package hps_pkg;
	localparam int DEPTH = 64;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = 34;
	localparam int EW = 57;

	localparam logic [1:0] ST_INS   = 2'd0;
	localparam logic [1:0] ST_DISP  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic OP_INSERT   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] prio;
		logic [16:0] elapsed;
		logic [15:0] total;
	} entry_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  task_id;
		logic [15:0] priority_req;
		logic [15:0] start_elapsed;
		logic [15:0] total_time;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_task_id;
		logic [16:0] out_elapsed;
		logic        finished;
		logic [31:0] switch_count;
		logic [6:0]  queue_size;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_XKEY, S_UP_RD, S_UP_MUL, S_UP_CMP, S_PLACE,
		S_DN_CHK, S_DN_ML, S_DN_MR, S_DN_CMP, S_D_ROOT, S_D_LAST, S_REQ, S_FIN
	} state_t;
endpackage

// ===== hw/rtl/hps_ram.sv =====
// hps_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module hps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/heap_priority_scheduler.sv =====
// heap_priority_scheduler: min-heap task scheduler with one shared key multiplier.
// Depends on hps_pkg and hps_ram.
`timescale 1ns / 1ps
//  channel  | ports                  | handshake
//  request  | start, busy, request   | taken when start && !busy
//  result   | done, result           | one-cycle strobe, no back-pressure
//
// One request at a time. Insert: key, then per parent compared (up to
// log2(DEPTH)) a read, multiply and compare, then place. Dispatch: root and
// last reads, key, then per level down up to two child reads through the one
// RAM read port and the one multiplier and a compare, place, requeue decision,
// then a reinsert climb as for an insert. Full and empty cases go straight to
// the finish state. The done strobe follows the last busy cycle. Reset clears
// count, switch counter and the sequencer; heap RAM contents are not cleared.
module heap_priority_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hps_pkg::in_t  request,
	output logic          done,
	output hps_pkg::out_t result
);
	import hps_pkg::*;

	state_t state_q, state_d;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] count_q;
	logic [31:0] switches_q;
	entry_t x_q, cur_q, ent_a_q, ent_b_q;
	logic [KW-1:0] key_x_q, key_a_q, key_b_q;
	logic rv_q, dn_q, fin_q, done_q;
	logic [1:0] status_q;
	out_t res_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata;
	logic [EW-1:0] ram_rdata;
	entry_t rd_ent;
	entry_t mul_ent;
	logic [KW-1:0] mul_key;
	logic [AW-1:0] parent;
	logic [CW:0] lft, rgt;
	logic sel_l, sel_r;
	logic [KW-1:0] best_key;
	logic [16:0] new_el;

	hps_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign rd_ent = entry_t'(ram_rdata);

	// shared key unit: prio * (elapsed + 1)
	assign mul_ent = (state_q == S_XKEY) ? x_q : rd_ent;
	assign mul_key = KW'(mul_ent.prio) * KW'({1'b0, mul_ent.elapsed} + 18'd1);

	// index arithmetic and compares
	assign parent   = AW'((pos_q - AW'(1)) >> 1);
	assign lft      = ((CW+1)'(pos_q) << 1) + (CW+1)'(1);
	assign rgt      = lft + (CW+1)'(1);
	assign sel_l    = key_x_q > key_a_q;
	assign best_key = sel_l ? key_a_q : key_x_q;
	assign sel_r    = rv_q && (best_key > key_b_q);
	assign new_el   = cur_q.elapsed + 17'(cur_q.prio);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (request.op == OP_INSERT) begin
						state_d = (count_q >= CW'(DEPTH)) ? S_FIN : S_XKEY;
					end else begin
						state_d = (count_q == '0) ? S_FIN : S_D_ROOT;
					end
				end
			end
			S_D_ROOT: state_d = S_D_LAST;
			S_D_LAST: state_d = (count_q == CW'(1)) ? S_REQ : S_XKEY;
			S_XKEY: begin
				if (dn_q) state_d = S_DN_CHK;
				else state_d = (pos_q == '0) ? S_PLACE : S_UP_RD;
			end
			S_UP_RD: state_d = S_UP_MUL;
			S_UP_MUL: state_d = S_UP_CMP;
			S_UP_CMP: begin
				if (key_a_q > key_x_q) state_d = (parent == '0) ? S_PLACE : S_UP_RD;
				else state_d = S_PLACE;
			end
			S_PLACE: state_d = dn_q ? S_REQ : S_FIN;
			S_DN_CHK: state_d = (lft >= (CW+1)'(count_q)) ? S_PLACE : S_DN_ML;
			S_DN_ML: state_d = (rgt < (CW+1)'(count_q)) ? S_DN_MR : S_DN_CMP;
			S_DN_MR: state_d = S_DN_CMP;
			S_DN_CMP: state_d = (sel_r || sel_l) ? S_DN_CHK : S_PLACE;
			S_REQ: state_d = (new_el < 17'(cur_q.total)) ? S_XKEY : S_FIN;
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_q;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: ram_raddr = '0;
			S_D_ROOT: ram_raddr = AW'(count_q - CW'(1));
			S_UP_RD: ram_raddr = parent;
			S_UP_CMP: begin
				ram_we    = key_a_q > key_x_q;
				ram_wdata = ent_a_q;
			end
			S_PLACE: ram_we = 1'b1;
			S_DN_CHK: ram_raddr = AW'(lft);
			S_DN_ML: ram_raddr = AW'(rgt);
			S_DN_CMP: begin
				ram_we    = sel_r || sel_l;
				ram_wdata = sel_r ? ent_b_q : ent_a_q;
			end
			default: ram_raddr = '0;
		endcase
	end

	// sequencer state and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			switches_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
			if (state_q == S_IDLE && start && request.op == OP_INSERT &&
			    count_q < CW'(DEPTH)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_D_LAST) begin
				count_q <= count_q - CW'(1);
				if (switches_q != 32'hFFFF_FFFF) switches_q <= switches_q + 32'd1;
			end
			if (state_q == S_REQ && new_el < 17'(cur_q.total)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rv_q <= 1'b0;
				fin_q <= 1'b0;
				dn_q <= 1'b0;
				x_q <= '{id: request.task_id, prio: request.priority_req,
				         elapsed: {1'b0, request.start_elapsed}, total: request.total_time};
				pos_q <= AW'(count_q);
				if (request.op == OP_INSERT)
					status_q <= (count_q >= CW'(DEPTH)) ? ST_FULL : ST_INS;
				else
					status_q <= (count_q == '0) ? ST_EMPTY : ST_DISP;
			end
			S_D_ROOT: cur_q <= rd_ent;
			S_D_LAST: begin
				x_q   <= rd_ent;
				pos_q <= '0;
				dn_q  <= 1'b1;
			end
			S_XKEY: key_x_q <= mul_key;
			S_UP_MUL: begin
				ent_a_q <= rd_ent;
				key_a_q <= mul_key;
			end
			S_UP_CMP: if (key_a_q > key_x_q) pos_q <= parent;
			S_DN_CHK: rv_q <= 1'b0;
			S_DN_ML: begin
				ent_a_q <= rd_ent;
				key_a_q <= mul_key;
			end
			S_DN_MR: begin
				ent_b_q <= rd_ent;
				key_b_q <= mul_key;
				rv_q    <= 1'b1;
			end
			S_DN_CMP: begin
				if (sel_r) pos_q <= AW'(rgt);
				else if (sel_l) pos_q <= AW'(lft);
			end
			S_REQ: begin
				cur_q.elapsed <= new_el;
				dn_q <= 1'b0;
				if (new_el < 17'(cur_q.total)) begin
					x_q   <= '{id: cur_q.id, prio: cur_q.prio, elapsed: new_el,
					         total: cur_q.total};
					pos_q <= AW'(count_q);
				end else begin
					fin_q <= 1'b1;
				end
			end
			S_FIN: begin
				res_q.status       <= status_q;
				res_q.out_task_id  <= (status_q == ST_DISP) ? cur_q.id : 8'd0;
				res_q.out_elapsed  <= (status_q == ST_DISP) ? cur_q.elapsed : 17'd0;
				res_q.finished     <= (status_q == ST_DISP) && fin_q;
				res_q.switch_count <= switches_q;
				res_q.queue_size   <= 7'(count_q);
			end
			default: rv_q <= rv_q;
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("heap count above depth");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken without going busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
endmodule

// ===== tb/tb_heap_priority_scheduler.sv =====
// Self-checking testbench for heap_priority_scheduler: directed and random requests
// checked against an in-bench heap scheduler prediction. Depends on hps_pkg.
`timescale 1ns / 1ps
module tb_heap_priority_scheduler;
	import hps_pkg::*;

	// Prediction of the scheduler plus the queue of expected results
	class sched_scoreboard;
		entry_t heap[DEPTH];
		int unsigned fill;
		logic [31:0] dispatches;
		out_t pending_q[$];
		int errors;

		function new();
			fill = 0;
			dispatches = '0;
			errors = 0;
		endfunction

		function logic [63:0] key_of(entry_t e);
			return 64'(e.prio) * (64'(e.elapsed) + 64'd1);
		endfunction

		function void swap_at(int unsigned a, int unsigned b);
			entry_t t;
			t = heap[a];
			heap[a] = heap[b];
			heap[b] = t;
		endfunction

		function void sift_up(int unsigned pos);
			int unsigned up;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (!(key_of(heap[up]) > key_of(heap[pos])))
					break;
				swap_at(up, pos);
				pos = up;
			end
		endfunction

		function void sift_down(int unsigned pos);
			int unsigned l, r, best;
			while (pos < fill) begin
				l = 2 * pos + 1;
				r = 2 * pos + 2;
				best = pos;
				if (l < fill && key_of(heap[best]) > key_of(heap[l]))
					best = l;
				if (r < fill && key_of(heap[best]) > key_of(heap[r]))
					best = r;
				if (best == pos)
					break;
				swap_at(pos, best);
				pos = best;
			end
		endfunction

		function bit push_entry(entry_t e);
			if (fill >= DEPTH)
				return 0;
			heap[fill] = e;
			fill++;
			sift_up(fill - 1);
			return 1;
		endfunction

		// Accepted request: work out its result and queue it
		function void note(in_t req);
			out_t r;
			entry_t e;
			r = '0;
			if (req.op == OP_INSERT) begin
				e.id = req.task_id;
				e.prio = req.priority_req;
				e.elapsed = {1'b0, req.start_elapsed};
				e.total = req.total_time;
				r.status = push_entry(e) ? ST_INS : ST_FULL;
			end else if (fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				e = heap[0];
				heap[0] = heap[fill - 1];
				fill--;
				if (fill > 0)
					sift_down(0);
				if (dispatches != 32'hFFFF_FFFF)
					dispatches++;
				e.elapsed = e.elapsed + 17'(e.prio);
				if (e.elapsed < 17'(e.total)) begin
					void'(push_entry(e));
					r.finished = 1'b0;
				end else begin
					r.finished = 1'b1;
				end
				r.status = ST_DISP;
				r.out_task_id = e.id;
				r.out_elapsed = e.elapsed;
			end
			r.switch_count = dispatches;
			r.queue_size = 7'(fill);
			pending_q.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		// Result strobe: compare with the oldest expectation
		task check(out_t got);
			out_t want;
			if (pending_q.size() == 0) begin
				report("unexpected result", 64'(got.status), 64'd0);
				return;
			end
			want = pending_q.pop_front();
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.out_task_id !== want.out_task_id)
				report("out_task_id", 64'(got.out_task_id), 64'(want.out_task_id));
			if (got.out_elapsed !== want.out_elapsed)
				report("out_elapsed", 64'(got.out_elapsed), 64'(want.out_elapsed));
			if (got.finished !== want.finished)
				report("finished", 64'(got.finished), 64'(want.finished));
			if (got.switch_count !== want.switch_count)
				report("switch_count", 64'(got.switch_count), 64'(want.switch_count));
			if (got.queue_size !== want.queue_size)
				report("queue_size", 64'(got.queue_size), 64'(want.queue_size));
		endtask
	endclass

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t request = '0;
	logic done;
	out_t result;

	sched_scoreboard sb = new();
	int idle_pct = 0;
	int stall_cycles = 0;

	heap_priority_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	// Result monitor
	always @(posedge clk) begin
		if (done)
			sb.check(result);
	end

	// Watchdog on cycles with neither a request taken nor a result
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Hold one request until taken; start stays high across back-to-back requests
	task send_request(in_t req);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		sb.note(req);
	endtask

	task send_insert(logic [7:0] id, logic [15:0] prio, logic [15:0] el, logic [15:0] tot);
		in_t req;
		req.op = OP_INSERT;
		req.task_id = id;
		req.priority_req = prio;
		req.start_elapsed = el;
		req.total_time = tot;
		send_request(req);
	endtask

	task send_dispatch();
		in_t req;
		req = in_t'($bits(in_t)'({$urandom, $urandom}));
		req.op = OP_DISPATCH;
		send_request(req);
	endtask

	// Random task with small priorities often, so keys tie
	task send_random_insert();
		logic [15:0] prio;
		logic [15:0] tot;
		prio = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(1, 65535));
		case ($urandom_range(2))
			0: tot = 16'($urandom_range(0, 40));
			1: tot = 16'($urandom_range(0, 65535));
			default: tot = 16'hFFFF;
		endcase
		send_insert(8'($urandom), prio, 16'($urandom_range(0, 65535)), tot);
	endtask

	initial begin
		int phase;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dispatch, field extremes, ties, finish and requeue
		send_dispatch();
		send_insert(8'h00, 16'd1, 16'd0, 16'd0);
		send_dispatch();
		send_dispatch();
		send_insert(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_insert(8'h01, 16'd1, 16'd0, 16'hFFFF);
		send_insert(8'h02, 16'd2, 16'd0, 16'd3);
		send_insert(8'h03, 16'd1, 16'd1, 16'd5);
		send_insert(8'h04, 16'd2, 16'd0, 16'd5);
		send_insert(8'hAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_insert(8'h55, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_insert(8'h10, 16'hFFFF, 16'd0, 16'hFFFF);
		repeat (10) send_dispatch();

		// Random phases: no idling, sender idle 75 of 100, none, sender idle 16 of 100
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 75;
				3: idle_pct = 16;
				default: idle_pct = 0;
			endcase
			// fill past capacity, then drain partly
			while (sb.fill < DEPTH) send_random_insert();
			repeat (3) send_random_insert();
			repeat (30) send_dispatch();
			for (n = 0; n < 70; n++) begin
				if ((sb.fill < 10 && $urandom_range(99) < 70) ||
				    (sb.fill >= 10 && $urandom_range(1) == 0))
					send_random_insert();
				else
					send_dispatch();
			end
			// long-running tasks keep requeueing, so the drain is bounded
			for (n = 0; n < 40 && sb.fill > 0; n++) send_dispatch();
			send_dispatch();
		end

		start <= 1'b0;
		while (sb.pending_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
